@@ sv/lvc_pkg.sv @@
// Package with shared types and constants for the exclusive cache hierarchy.
`timescale 1ns / 1ps
package lvc_pkg;
  localparam int unsigned SETS_DEF = 16;
  localparam int unsigned L2_WAYS_DEF = 8;
  localparam int unsigned VC_ENTRIES_DEF = 4;
  localparam int unsigned OFFSET_BITS = 2;
  localparam int unsigned LINENO_W = 32 - OFFSET_BITS;

  // Where the addressed line was found.
  typedef enum logic [1:0] {
    SRV_L1  = 2'd0,
    SRV_VC  = 2'd1,
    SRV_L2  = 2'd2,
    SRV_MEM = 2'd3
  } served_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOKUP,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic lookup;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dummy;
  } status_t;

  // Replace byte off of a line.
  function automatic logic [31:0] put_byte(input logic [31:0] line,
                                           input logic [1:0] off,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = line;
    r[8*off +: 8] = b;
    return r;
  endfunction
endpackage

@@ sv/l1_victim_l2_exclusive_cache.sv @@
// Top level of the exclusive L1, victim cache and L2 byte cache hierarchy.
// Sequence: an item is accepted in IDLE, then passes through READ (L2 row read),
// LOOKUP and UPDATE, and its result is valid in OUT until it is taken.
// Occupancy: the sequencer handles one item at a time through the L2 row read and
// update, and accepts no new item until the result has been taken.
// Reset: synchronous active-low; clears all valid bits and load counters, sets every
// victim rank to its entry number and makes every L2 rank read as its way number.
`timescale 1ns / 1ps
module l1_victim_l2_exclusive_cache #(
  parameter int unsigned SETS = lvc_pkg::SETS_DEF,
  parameter int unsigned L2_WAYS = lvc_pkg::L2_WAYS_DEF,
  parameter int unsigned VICTIM_ENTRIES = lvc_pkg::VC_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_store_data,
  input  logic [31:0] in_mem_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_load_data,
  output logic [1:0]  out_served_by,
  output logic [31:0] out_l1_accesses,
  output logic [31:0] out_l1_misses,
  output logic [31:0] out_victim_accesses,
  output logic [31:0] out_victim_misses,
  output logic [31:0] out_l2_accesses,
  output logic [31:0] out_l2_misses
);
  import lvc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  lvc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  lvc_dp #(.SETS(SETS), .L2_WAYS(L2_WAYS), .VC_ENTRIES(VICTIM_ENTRIES)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_op, .in_address, .in_store_data, .in_mem_line,
    .out_load_data, .out_served_by, .out_l1_accesses, .out_l1_misses,
    .out_victim_accesses, .out_victim_misses, .out_l2_accesses, .out_l2_misses
  );

  // A waiting result stays valid and unchanged.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_load_data) &&
    $stable(out_served_by) && $stable(out_l1_accesses))
    else $error("result changed while waiting");

  // The two channels are never both open in one cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open together");

  // The L1 access counter holds still in the cycle after a result is taken.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> $stable(out_l1_accesses))
    else $error("counter changed after result");
endmodule

@@ sv/lvc_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module lvc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  lvc_pkg::status_t sts,
  output lvc_pkg::cmd_t   cmd
);
  import lvc_pkg::*;

  state_t state_r, state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      ST_READ:   cmd.read = 1'b1;
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_UPDATE: cmd.update = ~sts.dummy | sts.dummy;
      ST_OUT:    out_valid = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

@@ sv/lvc_dp.sv @@
// Datapath with the L1, victim and L2 stores, lookup and update logic.
`timescale 1ns / 1ps
module lvc_dp #(
  parameter int unsigned SETS = lvc_pkg::SETS_DEF,
  parameter int unsigned L2_WAYS = lvc_pkg::L2_WAYS_DEF,
  parameter int unsigned VC_ENTRIES = lvc_pkg::VC_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lvc_pkg::cmd_t     cmd,
  output lvc_pkg::status_t  sts,
  input  logic              in_op,
  input  logic [31:0]       in_address,
  input  logic [7:0]        in_store_data,
  input  logic [31:0]       in_mem_line,
  output logic [7:0]        out_load_data,
  output logic [1:0]        out_served_by,
  output logic [31:0]       out_l1_accesses,
  output logic [31:0]       out_l1_misses,
  output logic [31:0]       out_victim_accesses,
  output logic [31:0]       out_victim_misses,
  output logic [31:0]       out_l2_accesses,
  output logic [31:0]       out_l2_misses
);
  import lvc_pkg::*;

  localparam int unsigned IW = $clog2(SETS);
  localparam int unsigned VW = $clog2(VC_ENTRIES);
  localparam int unsigned WW = $clog2(L2_WAYS);
  localparam int unsigned L2D = SETS * L2_WAYS;
  localparam int unsigned L2AW = IW + WW;

  typedef logic [LINENO_W-1:0] lineno_t;

  // L1 stores: valid bits in flops, tags and lines in arrays.
  logic [SETS-1:0]   l1_v_r;
  lineno_t           l1_tag_r  [SETS];
  logic [31:0]       l1_line_r [SETS];
  // Victim cache.
  logic [VC_ENTRIES-1:0] vc_v_r;
  lineno_t           vc_tag_r  [VC_ENTRIES];
  logic [31:0]       vc_line_r [VC_ENTRIES];
  logic [VW-1:0]     vc_rank_r [VC_ENTRIES];
  // L2: one row per set in memories, valid bits per entry in flops.
  logic [L2D-1:0]    l2_v_r;
  logic [L2_WAYS*LINENO_W-1:0] l2_tag_mem [SETS];
  logic [L2_WAYS*32-1:0]       l2_line_mem [SETS];
  logic [L2_WAYS*WW-1:0]       l2_rank_mem [SETS];
  logic [SETS-1:0]   l2_rank_ok_r;

  logic [31:0] cnt_r [6];

  // Captured item.
  logic        op_r;
  logic [1:0]  off_r;
  lineno_t     ln_r;
  logic [IW-1:0] idx_r;
  logic [7:0]  sd_r;
  logic [31:0] ml_r;

  // Registered L2 row reads.
  logic [L2_WAYS*LINENO_W-1:0] rtag_r;
  logic [L2_WAYS*32-1:0]       rline_r;
  logic [L2_WAYS*WW-1:0]       rrank_r;
  // Registered rank row of the set that a cascade would spill into.
  logic [L2_WAYS*WW-1:0]       crank_r;

  // Lookup results.
  logic [1:0]  srv_r;
  logic [VW-1:0] vhit_r;
  logic [WW-1:0] l2hit_r;

  logic [7:0]  ld_r;
  logic [1:0]  srvo_r;

  assign sts.dummy = 1'b0;

  logic [L2AW-1:0] row_base;
  assign row_base = {idx_r, {WW{1'b0}}};

  // Effective L2 rank of way w in the read row.
  function automatic logic [WW-1:0] l2r(input logic [L2_WAYS*WW-1:0] row,
                                        input logic ok, input int w);
    return ok ? row[w*WW +: WW] : WW'(w);
  endfunction

  // Lookup combinational search.
  logic          vc_hit_c, l2_hit_c;
  logic [VW-1:0] vhit_c;
  logic [WW-1:0] l2hit_c;
  always_comb begin
    vc_hit_c = 1'b0; vhit_c = '0;
    for (int i = VC_ENTRIES - 1; i >= 0; i--) begin
      if (vc_v_r[i] && vc_tag_r[i] == ln_r) begin
        vc_hit_c = 1'b1; vhit_c = VW'(i);
      end
    end
    l2_hit_c = 1'b0; l2hit_c = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (l2_v_r[row_base + L2AW'(w)] && rtag_r[w*LINENO_W +: LINENO_W] == ln_r) begin
        l2_hit_c = 1'b1; l2hit_c = WW'(w);
      end
    end
  end

  // Update stage: work out the new state of every store.
  logic [31:0]   hline;
  logic          l1_old_v;
  lineno_t       l1_old_tag;
  logic [31:0]   l1_old_line;
  logic [VW-1:0] vpick;
  logic          vpick_found;
  logic          cas_vc, cas_l2;
  lineno_t       cas_tag;
  logic [31:0]   cas_line;
  logic [IW-1:0] cas_set;
  logic          freed_same;
  logic [WW-1:0] wpick;
  logic          wfound;
  logic [VW-1:0] vtouch;
  logic          do_vtouch;
  always_comb begin
    l1_old_v = l1_v_r[idx_r];
    l1_old_tag = l1_tag_r[idx_r];
    l1_old_line = l1_line_r[idx_r];
    case (srv_r)
      SRV_L1:  hline = l1_old_line;
      SRV_VC:  hline = vc_line_r[vhit_r];
      SRV_L2:  hline = rline_r[l2hit_r*32 +: 32];
      default: hline = ml_r;
    endcase
    // Victim replacement choice.
    vpick = '0; vpick_found = 1'b0;
    for (int i = VC_ENTRIES - 1; i >= 0; i--) begin
      if (!vc_v_r[i]) begin vpick = VW'(i); vpick_found = 1'b1; end
    end
    if (!vpick_found) begin
      for (int i = VC_ENTRIES - 1; i >= 0; i--) begin
        if (vc_rank_r[i] == '0) vpick = VW'(i);
      end
    end
    // A load from L2 or memory evicts a valid L1 line into the victim cache.
    cas_vc = !op_r && (srv_r == SRV_L2 || srv_r == SRV_MEM) && l1_old_v;
    cas_l2 = cas_vc && vc_v_r[vpick];
    cas_tag = vc_tag_r[vpick];
    cas_line = vc_line_r[vpick];
    cas_set = cas_tag[IW-1:0];
    do_vtouch = (op_r && srv_r == SRV_VC) || (!op_r && srv_r == SRV_VC && l1_old_v)
                || cas_vc;
    vtouch = cas_vc ? vpick : vhit_r;
    // The way freed by a promotion is already free when the cascade lands in its set.
    freed_same = (srv_r == SRV_L2) && (cas_set == idx_r);
    wpick = '0; wfound = 1'b0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (!l2_v_r[{cas_set, WW'(w)}] || (freed_same && l2hit_r == WW'(w))) begin
        wpick = WW'(w); wfound = 1'b1;
      end
    end
    if (!wfound) begin
      for (int w = L2_WAYS - 1; w >= 0; w--) begin
        if (crank_r[w*WW +: WW] == '0) wpick = WW'(w);
      end
    end
  end

  // Touch a rank row at index t.
  function automatic logic [L2_WAYS*WW-1:0] touch_l2(input logic [L2_WAYS*WW-1:0] row,
                                                     input logic [WW-1:0] t);
    logic [L2_WAYS*WW-1:0] r;
    logic [WW-1:0] rt;
    r = row;
    rt = row[t*WW +: WW];
    for (int w = 0; w < L2_WAYS; w++) begin
      if (row[w*WW +: WW] > rt) r[w*WW +: WW] = row[w*WW +: WW] - 1'b1;
    end
    r[t*WW +: WW] = WW'(L2_WAYS - 1);
    return r;
  endfunction

  logic [L2_WAYS*WW-1:0] hrank;
  always_comb begin
    hrank = '0;
    for (int w = 0; w < L2_WAYS; w++) hrank[w*WW +: WW] = rrank_r[w*WW +: WW];
  end

  // Control registers: valid bits, ranks, counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_v_r <= '0;
      vc_v_r <= '0;
      l2_v_r <= '0;
      l2_rank_ok_r <= '0;
      for (int i = 0; i < VC_ENTRIES; i++) vc_rank_r[i] <= VW'(i);
      for (int i = 0; i < 6; i++) cnt_r[i] <= '0;
    end else if (cmd.update) begin
      // Counters count loads only.
      if (!op_r) begin
        cnt_r[0] <= cnt_r[0] + 32'd1;
        if (srv_r != SRV_L1) begin
          cnt_r[1] <= cnt_r[1] + 32'd1;
          cnt_r[2] <= cnt_r[2] + 32'd1;
        end
        if (srv_r == SRV_L2 || srv_r == SRV_MEM) begin
          cnt_r[3] <= cnt_r[3] + 32'd1;
          cnt_r[4] <= cnt_r[4] + 32'd1;
        end
        if (srv_r == SRV_MEM) cnt_r[5] <= cnt_r[5] + 32'd1;
      end
      // Victim rank touch.
      if (do_vtouch) begin
        for (int i = 0; i < VC_ENTRIES; i++) begin
          if (VW'(i) != vtouch && vc_rank_r[i] > vc_rank_r[vtouch])
            vc_rank_r[i] <= vc_rank_r[i] - 1'b1;
        end
        vc_rank_r[vtouch] <= VW'(VC_ENTRIES - 1);
      end
      if (!op_r) begin
        case (srv_r)
          SRV_VC: begin
            l1_v_r[idx_r] <= 1'b1;
            if (!l1_old_v) vc_v_r[vhit_r] <= 1'b0;
          end
          SRV_L2, SRV_MEM: begin
            l1_v_r[idx_r] <= 1'b1;
            if (srv_r == SRV_L2) l2_v_r[row_base + L2AW'(l2hit_r)] <= 1'b0;
            if (cas_vc) vc_v_r[vpick] <= 1'b1;
            if (cas_l2) begin
              l2_v_r[{cas_set, wpick}] <= 1'b1;
              l2_rank_ok_r[cas_set] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end else if (srv_r == SRV_L2) begin
        l2_rank_ok_r[idx_r] <= 1'b1;
      end
    end
  end

  // Payload registers and stores.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      off_r <= in_address[1:0];
      ln_r  <= in_address[31:OFFSET_BITS];
      idx_r <= in_address[OFFSET_BITS +: IW];
      sd_r  <= in_store_data;
      ml_r  <= in_mem_line;
    end
    if (cmd.read) begin
      rtag_r  <= l2_tag_mem[idx_r];
      rline_r <= l2_line_mem[idx_r];
      for (int w = 0; w < L2_WAYS; w++) begin
        rrank_r[w*WW +: WW] <= l2r(l2_rank_mem[idx_r], l2_rank_ok_r[idx_r], w);
        crank_r[w*WW +: WW] <= l2r(l2_rank_mem[cas_set], l2_rank_ok_r[cas_set], w);
      end
    end
    if (cmd.lookup) begin
      if (l1_v_r[idx_r] && l1_tag_r[idx_r] == ln_r) srv_r <= SRV_L1;
      else if (vc_hit_c) srv_r <= SRV_VC;
      else if (l2_hit_c) srv_r <= SRV_L2;
      else srv_r <= SRV_MEM;
      vhit_r <= vhit_c;
      l2hit_r <= l2hit_c;
    end
    if (cmd.update) begin
      srvo_r <= srv_r;
      ld_r <= op_r ? 8'd0 : hline[8*off_r +: 8];
      if (op_r) begin
        case (srv_r)
          SRV_L1: l1_line_r[idx_r] <= put_byte(l1_old_line, off_r, sd_r);
          SRV_VC: vc_line_r[vhit_r] <= put_byte(vc_line_r[vhit_r], off_r, sd_r);
          SRV_L2: begin
            l2_line_mem[idx_r][l2hit_r*32 +: 32] <=
              put_byte(rline_r[l2hit_r*32 +: 32], off_r, sd_r);
            l2_rank_mem[idx_r] <= touch_l2(hrank, l2hit_r);
          end
          default: begin
          end
        endcase
      end else if (srv_r != SRV_L1) begin
        l1_tag_r[idx_r] <= ln_r;
        l1_line_r[idx_r] <= hline;
        if (srv_r == SRV_VC) begin
          vc_tag_r[vhit_r] <= l1_old_tag;
          vc_line_r[vhit_r] <= l1_old_line;
        end else if (cas_vc) begin
          vc_tag_r[vpick] <= l1_old_tag;
          vc_line_r[vpick] <= l1_old_line;
          if (cas_l2) begin
            l2_tag_mem[cas_set][wpick*LINENO_W +: LINENO_W] <= cas_tag;
            l2_line_mem[cas_set][wpick*32 +: 32] <= cas_line;
            l2_rank_mem[cas_set] <= touch_l2(crank_r, wpick);
          end
        end
      end
    end
  end

  assign out_load_data = ld_r;
  assign out_served_by = srvo_r;
  assign out_l1_accesses = cnt_r[0];
  assign out_l1_misses = cnt_r[1];
  assign out_victim_accesses = cnt_r[2];
  assign out_victim_misses = cnt_r[3];
  assign out_l2_accesses = cnt_r[4];
  assign out_l2_misses = cnt_r[5];
endmodule
